// File: sv/psfl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package psfl_pkg;

   localparam int SIZE_W = 13;   // slot size register
   localparam int OFF_W  = 13;   // slot offsets on the ports
   localparam int LINK_W = 16;   // next field of a link word, head and tail
   localparam int SUM_W  = 17;   // walk arithmetic, holds page end plus one slot
   localparam int WORD_W = 32;   // page word

   localparam logic [SIZE_W-1:0] SLOT_SIZE_RESET = 13'd8;

   // opcodes
   localparam logic [1:0] OP_FORMAT = 2'd0;
   localparam logic [1:0] OP_ALLOC  = 2'd1;
   localparam logic [1:0] OP_FREE   = 2'd2;

   // status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_FULL     = 2'd1;
   localparam logic [1:0] ST_BAD_OFFS = 2'd2;

   // list events
   localparam logic [1:0] EV_NONE     = 2'd0;
   localparam logic [1:0] EV_BECAME_FULL = 2'd1;
   localparam logic [1:0] EV_REJOINED = 2'd2;

   typedef struct packed {
      logic              busy;
      logic              done;
      logic [LINK_W-1:0] tail;
   } fmt_status_type;

   // link word: size in the upper half, next offset in the lower half
   function automatic logic [WORD_W-1:0] link_word(input logic [SIZE_W-1:0] size,
                                                   input logic [LINK_W-1:0] next);
      link_word = {{(WORD_W - LINK_W - SIZE_W){1'b0}}, size, next};
   endfunction

endpackage

`default_nettype wire

// File: sv/page_slot_free_list_allocator_top.sv
`timescale 1ns / 1ps
`default_nettype none

// free list allocator for fixed-size slots within one page of 32-bit words
// req channel carries one command per transfer: format, allocate or free,
// with the page kind for a format on req_tuser
// rsp channel returns exactly one result per command, in command order
// csr_wr_en/csr_wr_data set the slot size; write only while the block is idle
// path of each command, from accepting transfer to result in the output register:
//   free, misfit format, unused opcode, alloc on a full or last slot: loaded directly
//   alloc of a chained slot: through S_READ, the registered read of the link word
//   format: through S_FMT while the walker chains (PAGE_WORDS - HEADER_WORDS) / slot_size
//   slots; the walker writes one link word per cycle through the single write port
// one command is in flight at a time; a new command is taken once the
// previous one has finished and the output register is empty or draining
// a stalled receiver holds the result in the output register and the block
// stops taking commands until that result transfers
// reset is synchronous: page marked full, head and tail cleared, normal kind,
// slot size back to 8; page memory is not cleared and needs a format first
module page_slot_free_list_allocator_top #(
   parameter int PAGE_WORDS   = 8192,
   parameter int HEADER_WORDS = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // op[1:0], slot_offset_in[14:2], zero fill[15]
   input  wire logic [0:0]  req_tuser,   // copy_kind[0]
   // response channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [23:0] rsp_tdata,   // slot_offset_out[12:0], status[14:13],
                                         // list_event[16:15], zero fill[23:17]
   output logic      [0:0]  rsp_tuser,   // page_kind[0]
   // slot size register
   input  wire logic        csr_wr_en,
   input  wire logic [12:0] csr_wr_data
);

   localparam int AW = $clog2(PAGE_WORDS);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_READ = 2'd1;   // link word read in flight
   localparam logic [1:0] S_FMT  = 2'd2;   // walker chaining slots

   // request fields
   logic [1:0]                   req_op;
   logic [psfl_pkg::OFF_W-1:0]   req_offset;
   logic                         req_kind;
   logic                         req_fire;

   assign req_op     = req_tdata[1:0];
   assign req_offset = req_tdata[14:2];
   assign req_kind   = req_tuser[0];
   assign req_fire   = req_tvalid && req_tready;

   // list state
   logic [1:0]                   state_ff, state_in;
   logic [psfl_pkg::LINK_W-1:0]  head_ff, head_in;
   logic [psfl_pkg::LINK_W-1:0]  tail_ff, tail_in;
   logic                         full_ff, full_in;
   logic                         copy_ff, copy_in;
   logic [psfl_pkg::SIZE_W-1:0]  slot_size_ff;
   logic                         rd_oob_ff;

   // output register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [psfl_pkg::OFF_W-1:0]   rsp_off_ff;
   logic [1:0]                   rsp_status_ff;
   logic [1:0]                   rsp_event_ff;
   logic                         rsp_kind_ff;
   logic                         rsp_load;
   logic [psfl_pkg::OFF_W-1:0]   res_off;
   logic [1:0]                   res_status;
   logic [1:0]                   res_event;

   // memory ports
   logic                         free_we;
   logic [psfl_pkg::WORD_W-1:0]  free_data;
   logic                         fmt_we;
   logic [AW-1:0]                fmt_addr;
   logic [psfl_pkg::WORD_W-1:0]  fmt_data;
   logic                         mem_we;
   logic [AW-1:0]                mem_waddr;
   logic [psfl_pkg::WORD_W-1:0]  mem_wdata;
   logic [psfl_pkg::WORD_W-1:0]  mem_rdata;

   logic                         fmt_start;
   psfl_pkg::fmt_status_type     fmt_st;

   logic [psfl_pkg::SUM_W-1:0]   off_ext;
   logic [psfl_pkg::SUM_W-1:0]   head_ext;
   logic                         off_bad;
   logic                         fmt_fits;

   assign off_ext  = psfl_pkg::SUM_W'(req_offset);
   assign head_ext = psfl_pkg::SUM_W'(head_ff);
   assign off_bad  = (off_ext < psfl_pkg::SUM_W'(HEADER_WORDS)) ||
                     (off_ext >= psfl_pkg::SUM_W'(PAGE_WORDS));
   assign fmt_fits = (slot_size_ff != '0) &&
                     (psfl_pkg::SUM_W'(HEADER_WORDS) + psfl_pkg::SUM_W'(slot_size_ff)
                        <= psfl_pkg::SUM_W'(PAGE_WORDS));

   // one command at a time, result register must be free by the next edge
   assign req_tready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in   = state_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      full_in    = full_ff;
      copy_in    = copy_ff;
      rsp_load   = 1'b0;
      res_off    = '0;
      res_status = psfl_pkg::ST_OK;
      res_event  = psfl_pkg::EV_NONE;
      free_we    = 1'b0;
      free_data  = psfl_pkg::link_word(slot_size_ff, head_ff);
      fmt_start  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (req_op)
                  psfl_pkg::OP_FORMAT: begin
                     copy_in = req_kind;
                     if (fmt_fits) begin
                        fmt_start = 1'b1;
                        state_in  = S_FMT;
                     end else begin
                        // no slot fits: empty list
                        head_in  = '0;
                        tail_in  = '0;
                        full_in  = 1'b1;
                        rsp_load = 1'b1;
                     end
                  end
                  psfl_pkg::OP_ALLOC: begin
                     if (full_ff) begin
                        res_status = psfl_pkg::ST_FULL;
                        rsp_load   = 1'b1;
                     end else if (head_ff == '0) begin
                        // broken chain, close the page
                        res_status = psfl_pkg::ST_FULL;
                        res_event  = psfl_pkg::EV_BECAME_FULL;
                        full_in    = 1'b1;
                        head_in    = '0;
                        tail_in    = '0;
                        rsp_load   = 1'b1;
                     end else if (head_ff == tail_ff) begin
                        // last free slot goes out
                        res_off   = head_ff[psfl_pkg::OFF_W-1:0];
                        res_event = psfl_pkg::EV_BECAME_FULL;
                        full_in   = 1'b1;
                        head_in   = '0;
                        tail_in   = '0;
                        rsp_load  = 1'b1;
                     end else begin
                        state_in = S_READ;
                     end
                  end
                  psfl_pkg::OP_FREE: begin
                     if (off_bad) begin
                        res_status = psfl_pkg::ST_BAD_OFFS;
                        rsp_load   = 1'b1;
                     end else if (full_ff) begin
                        free_we   = 1'b1;
                        free_data = psfl_pkg::link_word(slot_size_ff, psfl_pkg::LINK_W'(0));
                        head_in   = psfl_pkg::LINK_W'(req_offset);
                        tail_in   = psfl_pkg::LINK_W'(req_offset);
                        full_in   = 1'b0;
                        res_event = psfl_pkg::EV_REJOINED;
                        rsp_load  = 1'b1;
                     end else begin
                        free_we  = 1'b1;
                        head_in  = psfl_pkg::LINK_W'(req_offset);
                        rsp_load = 1'b1;
                     end
                  end
                  default: begin
                     rsp_load = 1'b1;
                  end
               endcase
            end
         end
         S_READ: begin
            // link word of the old head is now on the read port
            res_off  = head_ff[psfl_pkg::OFF_W-1:0];
            head_in  = rd_oob_ff ? psfl_pkg::LINK_W'(0)
                                 : mem_rdata[psfl_pkg::LINK_W-1:0];
            rsp_load = 1'b1;
            state_in = S_IDLE;
         end
         S_FMT: begin
            if (fmt_st.done) begin
               head_in  = psfl_pkg::LINK_W'(HEADER_WORDS);
               tail_in  = fmt_st.tail;
               full_in  = 1'b0;
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         full_ff      <= 1'b1;
         copy_ff      <= 1'b0;
         slot_size_ff <= psfl_pkg::SLOT_SIZE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         full_ff      <= full_in;
         copy_ff      <= copy_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            slot_size_ff <= csr_wr_data;
         end
      end
      rd_oob_ff <= head_ext >= psfl_pkg::SUM_W'(PAGE_WORDS);
      if (rsp_load) begin
         rsp_off_ff    <= res_off;
         rsp_status_ff <= res_status;
         rsp_event_ff  <= res_event;
         rsp_kind_ff   <= copy_in;
      end
   end

   // format walker owns the write port while busy
   psfl_fmt #(
      .PAGE_WORDS   (PAGE_WORDS),
      .HEADER_WORDS (HEADER_WORDS),
      .AW           (AW)
   ) u_fmt (
      .clock     (clock),
      .reset     (reset),
      .start     (fmt_start),
      .slot_size (slot_size_ff),
      .mem_we    (fmt_we),
      .mem_addr  (fmt_addr),
      .mem_data  (fmt_data),
      .status    (fmt_st)
   );

   assign mem_we    = fmt_we || free_we;
   assign mem_waddr = fmt_we ? fmt_addr : off_ext[AW-1:0];
   assign mem_wdata = fmt_we ? fmt_data : free_data;

   // a free writes at its accepting edge, and any later alloc reads at its own
   // accepting edge, after that write, so head reads never need forwarding
   psfl_ram #(
      .WIDTH (psfl_pkg::WORD_W),
      .DEPTH (PAGE_WORDS)
   ) u_page_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (head_ff[AW-1:0]),
      .rdata (mem_rdata)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_event_ff, rsp_status_ff, rsp_off_ff};
   assign rsp_tuser  = rsp_kind_ff;

   // a new result never overwrites one that has not transferred
   a_rsp_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("result register overwritten");

   // a full page keeps an empty list
   a_full_empty_list: assert property (@(posedge clock) disable iff (reset)
      full_ff |-> (head_ff == '0) && (tail_ff == '0))
      else $error("full page with non-empty list");

   // link read is followed directly by idle and always yields a result
   a_read_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |=> (state_ff == S_IDLE) && rsp_valid_ff)
      else $error("link read did not complete");

   // walker runs exactly while the sequencer waits on it
   a_walker_in_fmt: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FMT) == fmt_st.busy)
      else $error("walker and sequencer disagree");

   // the two write sources never collide
   a_single_writer: assert property (@(posedge clock) disable iff (reset)
      !(fmt_we && free_we))
      else $error("page write collision");

endmodule

`default_nettype wire

// File: sv/psfl_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module psfl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8192
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

`default_nettype wire

// File: sv/psfl_fmt.sv
`timescale 1ns / 1ps
`default_nettype none

module psfl_fmt #(
   parameter int PAGE_WORDS   = 8192,
   parameter int HEADER_WORDS = 32,
   parameter int AW           = 13
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [psfl_pkg::SIZE_W-1:0]  slot_size,
   output logic                              mem_we,
   output logic      [AW-1:0]                mem_addr,
   output logic      [psfl_pkg::WORD_W-1:0]  mem_data,
   output psfl_pkg::fmt_status_type          status
);

   logic                         busy_ff, busy_in;
   logic [psfl_pkg::SUM_W-1:0]   pos_ff, pos_in;
   logic [psfl_pkg::SUM_W-1:0]   nxt_ff, nxt_in;
   logic [psfl_pkg::SUM_W-1:0]   nxt2;
   logic                         last;

   // slot after next decides whether the next slot still fits
   assign nxt2 = nxt_ff + psfl_pkg::SUM_W'(slot_size);
   assign last = nxt2 > psfl_pkg::SUM_W'(PAGE_WORDS);

   always_comb begin
      busy_in = busy_ff;
      pos_in  = pos_ff;
      nxt_in  = nxt_ff;
      if (start) begin
         busy_in = 1'b1;
         pos_in  = psfl_pkg::SUM_W'(HEADER_WORDS);
         nxt_in  = psfl_pkg::SUM_W'(HEADER_WORDS) + psfl_pkg::SUM_W'(slot_size);
      end else if (busy_ff) begin
         pos_in = nxt_ff;
         nxt_in = nxt2;
         if (last) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      pos_ff <= pos_in;
      nxt_ff <= nxt_in;
   end

   assign mem_we   = busy_ff;
   assign mem_addr = pos_ff[AW-1:0];
   assign mem_data = psfl_pkg::link_word(slot_size,
                        last ? psfl_pkg::LINK_W'(0) : nxt_ff[psfl_pkg::LINK_W-1:0]);

   assign status.busy = busy_ff;
   assign status.done = busy_ff && last;
   assign status.tail = pos_ff[psfl_pkg::LINK_W-1:0];

endmodule

`default_nettype wire

// File: verif/page_slot_checker.sv
`timescale 1ns / 1ps

module page_slot_checker #(
   parameter int PAGE_WORDS   = 8192,
   parameter int HEADER_WORDS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,    // op[1:0], slot_offset_in[14:2], zero fill[15]
   input  logic [0:0]  req_tuser,    // copy_kind[0]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,    // slot_offset_out[12:0], status[14:13],
                                     // list_event[16:15], zero fill[23:17]
   input  logic [0:0]  rsp_tuser,    // page_kind[0]
   input  logic        csr_wr_en,
   input  logic [12:0] csr_wr_data,
   output int          fail_count,
   output int          results_due
);

   localparam int AW = $clog2(PAGE_WORDS);

   typedef struct packed {
      logic [psfl_pkg::OFF_W-1:0] slot_off;
      logic [1:0]                 status;
      logic [1:0]                 list_evt;
      logic                       page_kind;
   } page_answer_type;

   // shadow copy of the page and its free list
   logic [psfl_pkg::WORD_W-1:0] page_mem [PAGE_WORDS];
   logic [psfl_pkg::LINK_W-1:0] head_off;
   logic [psfl_pkg::LINK_W-1:0] tail_off;
   logic                        page_is_full;
   logic                        page_is_copy;
   logic [psfl_pkg::SIZE_W-1:0] slot_words;
   page_answer_type             answers_due [$];
   int                          errors;

   function automatic logic [psfl_pkg::WORD_W-1:0] chain_link(
         input logic [psfl_pkg::LINK_W-1:0] nxt);
      return (psfl_pkg::WORD_W'(slot_words) << psfl_pkg::LINK_W) | psfl_pkg::WORD_W'(nxt);
   endfunction

   // chain every slot that fits, last one terminated with next = 0
   function automatic void format_page(input logic kind);
      int unsigned s;
      int unsigned pos;
      int unsigned nxt;
      int unsigned last;
      s            = 32'(slot_words);
      pos          = HEADER_WORDS;
      last         = 0;
      page_is_copy = kind;
      if (s == 0 || HEADER_WORDS + s > PAGE_WORDS) begin
         head_off     = '0;
         tail_off     = '0;
         page_is_full = 1'b1;
      end else begin
         while (pos + s <= PAGE_WORDS) begin
            nxt = pos + s;
            if (nxt + s > PAGE_WORDS)
               nxt = 0;
            page_mem[AW'(pos)] = chain_link(psfl_pkg::LINK_W'(nxt));
            last = pos;
            pos += s;
         end
         head_off     = psfl_pkg::LINK_W'(HEADER_WORDS);
         tail_off     = psfl_pkg::LINK_W'(last);
         page_is_full = 1'b0;
      end
   endfunction

   function automatic page_answer_type apply_command(input logic [1:0] op,
                                                     input logic [psfl_pkg::OFF_W-1:0] off,
                                                     input logic kind);
      page_answer_type ans;
      ans = '0;
      case (op)
         psfl_pkg::OP_FORMAT: format_page(kind);
         psfl_pkg::OP_ALLOC: begin
            if (page_is_full) begin
               ans.status = psfl_pkg::ST_FULL;
            end else if (head_off == '0) begin
               // broken chain: give up on the list
               ans.status   = psfl_pkg::ST_FULL;
               ans.list_evt = psfl_pkg::EV_BECAME_FULL;
               page_is_full = 1'b1;
               head_off     = '0;
               tail_off     = '0;
            end else begin
               ans.slot_off = head_off[psfl_pkg::OFF_W-1:0];
               if (head_off == tail_off) begin
                  ans.list_evt = psfl_pkg::EV_BECAME_FULL;
                  page_is_full = 1'b1;
                  head_off     = '0;
                  tail_off     = '0;
               end else if (head_off < PAGE_WORDS) begin
                  head_off = page_mem[AW'(head_off)][psfl_pkg::LINK_W-1:0];
               end else begin
                  head_off = '0;
               end
            end
         end
         psfl_pkg::OP_FREE: begin
            if (off < HEADER_WORDS || off >= PAGE_WORDS) begin
               ans.status = psfl_pkg::ST_BAD_OFFS;
            end else if (page_is_full) begin
               page_mem[AW'(off)] = chain_link('0);
               head_off           = psfl_pkg::LINK_W'(off);
               tail_off           = psfl_pkg::LINK_W'(off);
               page_is_full       = 1'b0;
               ans.list_evt       = psfl_pkg::EV_REJOINED;
            end else begin
               page_mem[AW'(off)] = chain_link(head_off);
               head_off           = psfl_pkg::LINK_W'(off);
            end
         end
         default: ;
      endcase
      ans.page_kind = page_is_copy;
      return ans;
   endfunction

   task automatic compare_field(input string name, input logic [15:0] want,
                                input logic [15:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      page_answer_type want;
      if (reset) begin
         head_off     = '0;
         tail_off     = '0;
         page_is_full = 1'b1;
         page_is_copy = 1'b0;
         slot_words   = psfl_pkg::SLOT_SIZE_RESET;
         answers_due.delete();
      end else begin
         if (rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
            if (answers_due.size() == 0) begin
               $error("result transfer with nothing outstanding: tdata %h", rsp_tdata);
               errors++;
            end else begin
               want = answers_due.pop_front();
               compare_field("slot_offset_out", 16'(want.slot_off), 16'(rsp_tdata[12:0]));
               compare_field("status", 16'(want.status), 16'(rsp_tdata[14:13]));
               compare_field("list_event", 16'(want.list_evt), 16'(rsp_tdata[16:15]));
               compare_field("zero fill", '0, 16'(rsp_tdata[23:17]));
               compare_field("page_kind", 16'(want.page_kind), 16'(rsp_tuser[0]));
            end
         end
         if (req_tvalid === 1'b1 && req_tready === 1'b1)
            answers_due.push_back(apply_command(req_tdata[1:0], req_tdata[14:2],
                                                req_tuser[0]));
         if (csr_wr_en === 1'b1)
            slot_words = csr_wr_data;
      end
      fail_count  <= errors;
      results_due <= answers_due.size();
   end

endmodule

// File: verif/tb_page_slot_free_list_allocator_top.sv
`timescale 1ns / 1ps

module tb_page_slot_free_list_allocator_top;

   localparam int PAGE_WORDS     = 8192;
   localparam int HEADER_WORDS   = 32;
   localparam int CYCLE_LIMIT    = 1000000;  // far beyond the slowest legal run
   localparam int RX_HOLD_CYCLES = 400;      // long receiver hold-off
   localparam int DRAIN_CYCLES   = 20;
   localparam int PHASES         = 16;
   localparam int PHASE_ITEMS    = 108;
   localparam logic [1:0] OP_UNUSED = 2'd3;  // opcode the block must ignore

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata   = '0;   // op[1:0], slot_offset_in[14:2], zero fill[15]
   logic [0:0]  req_tuser   = '0;   // copy_kind[0]
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [23:0] rsp_tdata;         // slot_offset_out[12:0], status[14:13],
                                   // list_event[16:15], zero fill[23:17]
   logic [0:0]  rsp_tuser;         // page_kind[0]
   logic        csr_wr_en   = 1'b0;
   logic [12:0] csr_wr_data = '0;

   int fail_count;
   int results_due;

   // run statistics for the summary
   int n_format, n_alloc, n_free, n_unused, n_sizes;
   int full_events, rejoin_events, holds_done, cycle_count;

   // sender burst bookkeeping and the pool of slots handed out by the block
   int          burst_left;
   int          hold_asks;
   logic [12:0] granted [$];
   logic [12:0] last_freed = 13'(HEADER_WORDS);

   page_slot_free_list_allocator_top #(
      .PAGE_WORDS   (PAGE_WORDS),
      .HEADER_WORDS (HEADER_WORDS)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // watches both channels, predicts every result and counts mismatches
   page_slot_checker #(
      .PAGE_WORDS   (PAGE_WORDS),
      .HEADER_WORDS (HEADER_WORDS)
   ) chk (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fail_count  (fail_count),
      .results_due (results_due)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // cycle counter doubling as the run's timeout
   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Regression FAIL");
      $finish;
   end

   // collect granted slots so that later frees are well formed,
   // and tally the list events for the summary
   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         if (rsp_tdata[14:13] == psfl_pkg::ST_OK && rsp_tdata[12:0] != '0)
            granted.push_back(rsp_tdata[12:0]);
         if (rsp_tdata[16:15] == psfl_pkg::EV_BECAME_FULL)
            full_events++;
         if (rsp_tdata[16:15] == psfl_pkg::EV_REJOINED)
            rejoin_events++;
      end
   end

   // receiver: changes its stall behaviour after each run of random length;
   // each hold asked for by the stimulus keeps tready low for a long stretch
   initial begin : receiver
      int mode;
      int run_left;
      int tick;
      mode     = 0;
      run_left = 0;
      tick     = 0;
      forever begin
         @(negedge clock);
         if (holds_done < hold_asks) begin
            rsp_tready <= 1'b0;
            repeat (RX_HOLD_CYCLES) @(negedge clock);
            holds_done++;
         end
         if (run_left == 0) begin
            mode     = $urandom_range(0, 3);
            run_left = $urandom_range(20, 200);
         end
         run_left--;
         tick++;
         case (mode)
            0:       rsp_tready <= 1'b1;                          // no stalls
            1:       rsp_tready <= 1'($urandom_range(0, 1));      // coin toss
            2:       rsp_tready <= ($urandom_range(0, 3) == 0);   // mostly stalled
            default: rsp_tready <= (tick % 3 != 0);               // fixed rhythm
         endcase
      end
   end

   // offer one command from a falling edge and hold it until the transfer;
   // between bursts the valid drops for a random gap
   task automatic issue(input logic [1:0] op, input logic [12:0] off, input logic kind);
      req_tdata  <= {1'b0, off, op};
      req_tuser  <= kind;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (req_tready !== 1'b1);
      @(negedge clock);
      case (op)
         psfl_pkg::OP_FORMAT: n_format++;
         psfl_pkg::OP_ALLOC:  n_alloc++;
         psfl_pkg::OP_FREE:   n_free++;
         default:             n_unused++;
      endcase
      if (burst_left > 0)
         burst_left--;
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
         burst_left = $urandom_range(1, 30);
      end
   endtask

   // stop offering and wait until every outstanding result has transferred
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (results_due != 0);
      @(negedge clock);
   endtask

   // slot size may only change while the block is idle
   task automatic write_slot_size(input logic [12:0] words);
      wait_idle();
      csr_wr_data <= words;
      csr_wr_en   <= 1'b1;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      n_sizes++;
   endtask

   // mostly well-formed alloc/free traffic, with some noise:
   // formats, the unused opcode, header offsets, arbitrary offsets, double frees
   task automatic random_command(input int alloc_pct);
      int          r;
      int          idx;
      logic [12:0] off;
      logic        kind;
      r    = $urandom_range(0, 99);
      off  = 13'($urandom_range(0, PAGE_WORDS - 1));
      kind = 1'($urandom_range(0, 1));
      if (r < 3) begin
         granted.delete();
         issue(psfl_pkg::OP_FORMAT, off, kind);
      end else if (r < 6) begin
         issue(OP_UNUSED, off, kind);
      end else if (r < 9) begin
         issue(psfl_pkg::OP_FREE, 13'($urandom_range(0, HEADER_WORDS - 1)), kind);
      end else if (r < 13) begin
         issue(psfl_pkg::OP_FREE, off, kind);
      end else if (r < 14) begin
         issue(psfl_pkg::OP_FREE, last_freed, kind);
      end else if (r < 14 + alloc_pct * 86 / 100 || granted.size() == 0) begin
         issue(psfl_pkg::OP_ALLOC, off, kind);
      end else begin
         idx        = $urandom_range(0, granted.size() - 1);
         last_freed = granted[idx];
         granted.delete(idx);
         issue(psfl_pkg::OP_FREE, last_freed, kind);
      end
   endtask

   initial begin : stimulus
      int          phase;
      int          k;
      int          alloc_pct;
      int unsigned s;
      burst_left = $urandom_range(1, 30);
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: page starts full with slot size 8
      issue(psfl_pkg::OP_ALLOC, 13'd0, 1'b0);                    // alloc on a full page
      issue(psfl_pkg::OP_FREE, 13'd0, 1'b1);                     // offset inside the header
      issue(psfl_pkg::OP_FREE, 13'(HEADER_WORDS - 1), 1'b0);     // last header word
      issue(psfl_pkg::OP_FREE, 13'(HEADER_WORDS), 1'b0);         // full page rejoins
      issue(psfl_pkg::OP_FREE, 13'(PAGE_WORDS - 1), 1'b1);       // highest offset
      issue(psfl_pkg::OP_ALLOC, 13'h1fff, 1'b1);
      issue(psfl_pkg::OP_ALLOC, 13'd0, 1'b0);                    // last slot, page full
      issue(OP_UNUSED, 13'h1fff, 1'b1);
      issue(psfl_pkg::OP_FREE, 13'(HEADER_WORDS), 1'b0);
      issue(psfl_pkg::OP_FREE, 13'(HEADER_WORDS), 1'b0);         // double free
      issue(psfl_pkg::OP_ALLOC, 13'd0, 1'b0);
      issue(psfl_pkg::OP_FORMAT, 13'd0, 1'b1);                   // copy page, 1020 slots
      issue(psfl_pkg::OP_ALLOC, 13'd0, 1'b0);
      issue(psfl_pkg::OP_ALLOC, 13'd0, 1'b0);
      issue(psfl_pkg::OP_FREE, 13'(HEADER_WORDS + 8), 1'b0);

      // slot sizes for which no slot fits
      write_slot_size(13'd0);
      issue(psfl_pkg::OP_FORMAT, 13'd0, 1'b0);
      issue(psfl_pkg::OP_ALLOC, 13'd0, 1'b0);
      write_slot_size(13'h1fff);
      issue(psfl_pkg::OP_FORMAT, 13'd0, 1'b1);
      write_slot_size(13'(PAGE_WORDS - HEADER_WORDS + 1));
      issue(psfl_pkg::OP_FORMAT, 13'd0, 1'b0);

      // exactly one slot fits
      write_slot_size(13'(PAGE_WORDS - HEADER_WORDS));
      issue(psfl_pkg::OP_FORMAT, 13'd0, 1'b0);
      issue(psfl_pkg::OP_ALLOC, 13'd0, 1'b0);
      issue(psfl_pkg::OP_ALLOC, 13'd0, 1'b0);
      issue(psfl_pkg::OP_FREE, 13'(HEADER_WORDS), 1'b1);

      // one-word slots, the longest format walk
      write_slot_size(13'd1);
      issue(psfl_pkg::OP_FORMAT, 13'd0, 1'b0);
      issue(psfl_pkg::OP_ALLOC, 13'd0, 1'b0);
      issue(psfl_pkg::OP_ALLOC, 13'd0, 1'b0);

      // random phases, each with its own slot size and fresh format
      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0:       s = 8;
            1:       s = PAGE_WORDS - HEADER_WORDS;
            2:       s = 1;
            3:       s = 64;
            4:       s = 500;
            5:       s = 0;
            6:       s = 96;
            7:       s = 1000;
            8:       s = 8191;
            9:       s = 33;
            10:      s = 2040;
            11:      s = 4080;
            12:      s = PAGE_WORDS - HEADER_WORDS + 1;
            13:      s = 130;
            default: s = $urandom_range(16, 1024);
         endcase
         write_slot_size(13'(s));
         granted.delete();
         issue(psfl_pkg::OP_FORMAT, 13'($urandom_range(0, PAGE_WORDS - 1)),
               1'($urandom_range(0, 1)));
         alloc_pct = $urandom_range(35, 75);
         for (k = 1; k < PHASE_ITEMS; k++) begin
            if (k == PHASE_ITEMS / 2)
               alloc_pct = $urandom_range(25, 85);
            // long receiver hold-off while commands keep coming
            if ((phase == 3 || phase == 11) && k == 30)
               hold_asks++;
            // sender pause until the block has drained
            if (phase == 7 && k == PHASE_ITEMS / 2)
               wait_idle();
            random_command(alloc_pct);
         end
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d commands: %0d format, %0d alloc, %0d free, %0d unused opcode",
               n_format + n_alloc + n_free + n_unused, n_format, n_alloc, n_free, n_unused);
      $display("%0d slot size writes, %0d page-full and %0d rejoin events,",
               n_sizes, full_events, rejoin_events);
      $display("%0d long holds, %0d cycles", holds_done, cycle_count);
      if (fail_count == 0 && results_due == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// File: sim.f
sv/psfl_pkg.sv
sv/psfl_ram.sv
sv/psfl_fmt.sv
sv/page_slot_free_list_allocator_top.sv
verif/page_slot_checker.sv
verif/tb_page_slot_free_list_allocator_top.sv
